[rtl/pad_pkg.sv]
package pad_pkg;

   typedef struct packed {
      logic [15:0] intensity_a;
      logic [15:0] intensity_b;
      logic [15:0] intensity_c;
      logic [15:0] intensity_d;
   } pad_req_type;

   typedef struct packed {
      logic signed [15:0] azimuth_angle;
      logic [15:0]        polarization_degree;
   } pad_rsp_type;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_S0 = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_S1 = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_S2 = 2'd2;

   localparam logic [63:0] ROW_S0_RESET = 64'h1000_1000_1000_1000;
   localparam logic [63:0] ROW_S1_RESET = 64'h0000_E000_0000_2000;
   localparam logic [63:0] ROW_S2_RESET = 64'hE000_0000_2000_0000;

   localparam int TERM_BITS = 35;
   localparam int CORDIC_STEPS = 18;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS = 16;

   localparam int AZ_LATENCY = CORDIC_STEPS + 3;
   localparam int DEG_LATENCY = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int AZ_PAD = DEG_LATENCY - AZ_LATENCY;
   localparam int PIPE_DEPTH = 2 + DEG_LATENCY;

   localparam logic signed [21:0] QUARTER_TURN = 22'sd524288;
   localparam logic signed [21:0] HALF_TURN = 22'sd1048576;
   localparam logic [15:0] DEGREE_ONE = 16'd32768;

   localparam logic [19:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
      20'd262144, 20'd154753, 20'd81767, 20'd41506, 20'd20834, 20'd10427,
      20'd5215, 20'd2608, 20'd1304, 20'd652, 20'd326, 20'd163,
      20'd81, 20'd41, 20'd20, 20'd10, 20'd5, 20'd3
   };

   typedef struct packed {
      logic s1_neg;
      logic s2_neg;
      logic u1_zero;
      logic u2_zero;
   } pad_az_flags_type;

   typedef struct packed {
      logic [23:0] v;
      logic        zero_mag;
      logic        s0_neg;
      logic        s0_zero;
      logic        sat;
   } pad_deg_ctx_type;

   function automatic logic [5:0] pad_msb(logic [TERM_BITS-1:0] value);
      logic [5:0] pos;
      pos = 6'd0;
      for (int i = 0; i < TERM_BITS; i++) begin
         if (value[i]) begin
            pos = 6'(i);
         end
      end
      return pos;
   endfunction

endpackage

[rtl/pad_azimuth.sv]
module pad_azimuth (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic signed [pad_pkg::TERM_BITS-1:0]  s1,
   input  logic signed [pad_pkg::TERM_BITS-1:0]  s2,
   output logic signed [15:0]                    angle
);

   localparam int N = pad_pkg::CORDIC_STEPS;
   localparam int W = pad_pkg::TERM_BITS;

   logic [W-1:0]              u1_ff, u2_ff, u1_in, u2_in;
   logic [5:0]                pos_ff, pos_in;
   pad_pkg::pad_az_flags_type fl0_ff, fl0_in;

   logic signed [33:0]        x_ff [0:N];
   logic signed [33:0]        y_ff [0:N];
   logic signed [21:0]        z_ff [0:N];
   pad_pkg::pad_az_flags_type fl_ff [0:N];

   logic signed [15:0]        angle_ff, angle_in;

   always_comb begin
      logic [W-1:0] m;
      u1_in = s1[W-1] ? W'(-s1) : W'(s1);
      u2_in = s2[W-1] ? W'(-s2) : W'(s2);
      m = (u1_in > u2_in) ? u1_in : u2_in;
      pos_in = pad_pkg::pad_msb(m);
      fl0_in.s1_neg = s1[W-1];
      fl0_in.s2_neg = s2[W-1];
      fl0_in.u1_zero = (u1_in == '0);
      fl0_in.u2_zero = (u2_in == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u1_ff <= u1_in;
         u2_ff <= u2_in;
         pos_ff <= pos_in;
         fl0_ff <= fl0_in;
      end
   end

   always_ff @(posedge clock) begin
      logic [W-1:0] a1, a2;
      if (pos_ff >= 6'd30) begin
         a1 = u1_ff >> (pos_ff - 6'd30);
         a2 = u2_ff >> (pos_ff - 6'd30);
      end else begin
         a1 = u1_ff << (6'd30 - pos_ff);
         a2 = u2_ff << (6'd30 - pos_ff);
      end
      if (advance) begin
         x_ff[0] <= signed'(a1[33:0]);
         y_ff[0] <= signed'(a2[33:0]);
         z_ff[0] <= '0;
         fl_ff[0] <= fl0_ff;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cordic
      logic signed [33:0] dx, dy;
      logic signed [21:0] step;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign step = signed'({2'b00, pad_pkg::ATAN_TABLE[i]});
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!y_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step;
            end
            fl_ff[i+1] <= fl_ff[i];
         end
      end
   end

   always_comb begin
      logic signed [21:0] zc, a;
      logic [21:0]        mag;
      logic [21:0]        rounded;
      pad_pkg::pad_az_flags_type f;
      f = fl_ff[N];
      if (z_ff[N] < 0) begin
         zc = '0;
      end else if (z_ff[N] > pad_pkg::QUARTER_TURN) begin
         zc = pad_pkg::QUARTER_TURN;
      end else begin
         zc = z_ff[N];
      end
      priority if (f.u1_zero && f.u2_zero) begin
         a = '0;
      end else if (f.u2_zero) begin
         a = f.s1_neg ? pad_pkg::HALF_TURN : 22'sd0;
      end else if (f.u1_zero) begin
         a = f.s2_neg ? -pad_pkg::QUARTER_TURN : pad_pkg::QUARTER_TURN;
      end else if (!f.s1_neg) begin
         a = f.s2_neg ? -zc : zc;
      end else begin
         a = f.s2_neg ? -(pad_pkg::HALF_TURN - zc) : (pad_pkg::HALF_TURN - zc);
      end
      mag = a[21] ? 22'(-a) : 22'(a);
      rounded = (mag + 22'd32) >> 6;
      angle_in = a[21] ? -signed'(rounded[15:0]) : signed'(rounded[15:0]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

[rtl/pad_degree.sv]
module pad_degree (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic signed [pad_pkg::TERM_BITS-1:0]  s0,
   input  logic signed [pad_pkg::TERM_BITS-1:0]  s1,
   input  logic signed [pad_pkg::TERM_BITS-1:0]  s2,
   output logic [15:0]                           degree
);

   localparam int W = pad_pkg::TERM_BITS;
   localparam int SN = pad_pkg::SQRT_STEPS;
   localparam int DN = pad_pkg::DIV_STEPS;

   logic [W-1:0]             u1_ff, u2_ff, v_ff;
   logic [5:0]               pos_ff;
   pad_pkg::pad_deg_ctx_type c0_ff, c1_ff, c2_ff, c3_ff;
   logic [23:0]              n1_ff, n2_ff;
   logic [47:0]              q1_ff, q2_ff, vv_ff;
   logic [61:0]              rad_ff;

   logic [61:0]              sn_ff [0:SN];
   logic [32:0]              srem_ff [0:SN];
   logic [30:0]              sroot_ff [0:SN];
   pad_pkg::pad_deg_ctx_type sc_ff [0:SN];

   logic [23:0]              drem_ff [0:DN];
   logic [15:0]              dbits_ff [0:DN];
   logic [15:0]              quo_ff [0:DN];
   pad_pkg::pad_deg_ctx_type dc_ff [0:DN];

   logic [15:0]              degree_ff;

   always_ff @(posedge clock) begin
      logic [W-1:0] a1, a2, av, m;
      a1 = s1[W-1] ? W'(-s1) : W'(s1);
      a2 = s2[W-1] ? W'(-s2) : W'(s2);
      av = s0[W-1] ? '0 : W'(s0);
      m = (a1 > a2) ? a1 : a2;
      m = (av > m) ? av : m;
      if (advance) begin
         u1_ff <= a1;
         u2_ff <= a2;
         v_ff <= av;
         pos_ff <= pad_pkg::pad_msb(m);
         c0_ff.v <= '0;
         c0_ff.zero_mag <= (a1 == '0) && (a2 == '0);
         c0_ff.s0_neg <= s0[W-1];
         c0_ff.s0_zero <= (s0 == '0);
         c0_ff.sat <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      logic [W-1:0] b1, b2, bv;
      if (pos_ff >= 6'd23) begin
         b1 = u1_ff >> (pos_ff - 6'd23);
         b2 = u2_ff >> (pos_ff - 6'd23);
         bv = v_ff >> (pos_ff - 6'd23);
      end else begin
         b1 = u1_ff << (6'd23 - pos_ff);
         b2 = u2_ff << (6'd23 - pos_ff);
         bv = v_ff << (6'd23 - pos_ff);
      end
      if (advance) begin
         n1_ff <= b1[23:0];
         n2_ff <= b2[23:0];
         c1_ff <= '{v: bv[23:0], zero_mag: c0_ff.zero_mag, s0_neg: c0_ff.s0_neg,
                    s0_zero: c0_ff.s0_zero, sat: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_ff <= n1_ff * n1_ff;
         q2_ff <= n2_ff * n2_ff;
         vv_ff <= c1_ff.v * c1_ff.v;
         c2_ff <= c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [48:0] q;
      q = {1'b0, q1_ff} + {1'b0, q2_ff};
      if (advance) begin
         rad_ff <= {q[47:0], 14'd0};
         c3_ff <= '{v: c2_ff.v, zero_mag: c2_ff.zero_mag, s0_neg: c2_ff.s0_neg,
                    s0_zero: c2_ff.s0_zero, sat: (q >= {1'b0, vv_ff})};
      end
   end

   assign sn_ff[0] = rad_ff;
   assign srem_ff[0] = '0;
   assign sroot_ff[0] = '0;
   assign sc_ff[0] = c3_ff;

   for (genvar k = 0; k < SN; k++) begin : g_sqrt
      logic [32:0] t, trial;
      assign t = {srem_ff[k][30:0], sn_ff[k][61:60]};
      assign trial = {sroot_ff[k][30:0], 2'b01};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (t >= trial) begin
               srem_ff[k+1] <= t - trial;
               sroot_ff[k+1] <= {sroot_ff[k][29:0], 1'b1};
            end else begin
               srem_ff[k+1] <= t;
               sroot_ff[k+1] <= {sroot_ff[k][29:0], 1'b0};
            end
            sn_ff[k+1] <= {sn_ff[k][59:0], 2'b00};
            sc_ff[k+1] <= sc_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [39:0] num;
      num = {1'b0, sroot_ff[SN], 8'd0} + {17'd0, sc_ff[SN].v[23:1]};
      if (advance) begin
         drem_ff[0] <= num[39:16];
         dbits_ff[0] <= num[15:0];
         quo_ff[0] <= '0;
         dc_ff[0] <= sc_ff[SN];
      end
   end

   for (genvar j = 0; j < DN; j++) begin : g_div
      logic [24:0] t, dv;
      assign t = {drem_ff[j], dbits_ff[j][15]};
      assign dv = {1'b0, dc_ff[j].v};
      always_ff @(posedge clock) begin
         logic [24:0] diff;
         diff = t - dv;
         if (advance) begin
            if (t >= dv) begin
               drem_ff[j+1] <= diff[23:0];
               quo_ff[j+1] <= {quo_ff[j][14:0], 1'b1};
            end else begin
               drem_ff[j+1] <= t[23:0];
               quo_ff[j+1] <= {quo_ff[j][14:0], 1'b0};
            end
            dbits_ff[j+1] <= {dbits_ff[j][14:0], 1'b0};
            dc_ff[j+1] <= dc_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [15:0] d;
      pad_pkg::pad_deg_ctx_type c;
      c = dc_ff[DN];
      priority if (c.zero_mag || c.s0_neg) begin
         d = '0;
      end else if (c.s0_zero || c.sat) begin
         d = pad_pkg::DEGREE_ONE;
      end else if (quo_ff[DN] > pad_pkg::DEGREE_ONE) begin
         d = pad_pkg::DEGREE_ONE;
      end else begin
         d = quo_ff[DN];
      end
      if (advance) begin
         degree_ff <= d;
      end
   end

   assign degree = degree_ff;

endmodule

[rtl/polarization_angle_and_degree.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  pad_req_type (four intensities)
// rsp       out        rsp_valid/rsp_stall  pad_rsp_type (azimuth, degree)
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata (coefficient rows)
//
// One pixel enters per cycle unless a stalled result holds the pipeline; its depth is
// set by the 31-stage square root and 16-stage divider of the degree path.
// Reset clears the valid bits and loads the default coefficient rows.
// While a result waits under rsp_stall, the whole pipeline holds and req_stall is high.
module polarization_angle_and_degree #(
   parameter int INTENSITY_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pad_pkg::pad_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pad_pkg::pad_rsp_type                 rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pad_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [63:0]                          csr_wdata
);

   localparam int W = pad_pkg::TERM_BITS;

   logic [63:0]        row_ff [0:2];
   logic               vld_ff [0:pad_pkg::PIPE_DEPTH-1];
   logic               advance;
   logic signed [16:0] x [0:3];
   logic signed [32:0] prod_ff [0:2][0:3];
   logic signed [W-1:0] term_ff [0:2];
   logic signed [15:0] az_angle;
   logic signed [15:0] az_dly_ff [0:pad_pkg::AZ_PAD-1];
   logic [15:0]        degree;

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= pad_pkg::ROW_S0_RESET;
         row_ff[1] <= pad_pkg::ROW_S1_RESET;
         row_ff[2] <= pad_pkg::ROW_S2_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pad_pkg::CSR_ROW_S0: row_ff[0] <= csr_wdata;
            pad_pkg::CSR_ROW_S1: row_ff[1] <= csr_wdata;
            pad_pkg::CSR_ROW_S2: row_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pad_pkg::PIPE_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < pad_pkg::PIPE_DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign x[0] = signed'({{(17-INTENSITY_BITS){1'b0}},
                          req_data.intensity_a[INTENSITY_BITS-1:0]});
   assign x[1] = signed'({{(17-INTENSITY_BITS){1'b0}},
                          req_data.intensity_b[INTENSITY_BITS-1:0]});
   assign x[2] = signed'({{(17-INTENSITY_BITS){1'b0}},
                          req_data.intensity_c[INTENSITY_BITS-1:0]});
   assign x[3] = signed'({{(17-INTENSITY_BITS){1'b0}},
                          req_data.intensity_d[INTENSITY_BITS-1:0]});

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 4; k++) begin
               prod_ff[r][k] <= 33'(signed'(row_ff[r][16*k +: 16]) * x[k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            term_ff[r] <= W'(prod_ff[r][0]) + W'(prod_ff[r][1])
                        + W'(prod_ff[r][2]) + W'(prod_ff[r][3]);
         end
      end
   end

   pad_azimuth u_azimuth (
      .clock   (clock),
      .advance (advance),
      .s1      (term_ff[1]),
      .s2      (term_ff[2]),
      .angle   (az_angle)
   );

   pad_degree u_degree (
      .clock   (clock),
      .advance (advance),
      .s0      (term_ff[0]),
      .s1      (term_ff[1]),
      .s2      (term_ff[2]),
      .degree  (degree)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         az_dly_ff[0] <= az_angle;
         for (int i = 1; i < pad_pkg::AZ_PAD; i++) begin
            az_dly_ff[i] <= az_dly_ff[i-1];
         end
      end
   end

   assign rsp_valid = vld_ff[pad_pkg::PIPE_DEPTH-1];
   assign rsp_data.azimuth_angle = az_dly_ff[pad_pkg::AZ_PAD-1];
   assign rsp_data.polarization_degree = degree;

endmodule

[rtl/pad_checker.sv]
module pad_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input pad_pkg::pad_rsp_type                 rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed or vanished.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input taken while the result transfer is stalled.");

   a_degree_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.polarization_degree <= pad_pkg::DEGREE_ONE)
      else $error("Degree above one.");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.azimuth_angle >= -16'sd16384)
                 && (rsp_data.azimuth_angle <= 16'sd16384))
      else $error("Azimuth out of range.");

endmodule

bind polarization_angle_and_degree pad_checker u_pad_checker (.*);
